// ===== hw/rtl/per_channel_ratio_averager_core_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef PER_CHANNEL_RATIO_AVERAGER_CORE_MACROS_SVH
`define PER_CHANNEL_RATIO_AVERAGER_CORE_MACROS_SVH

// Checked at every edge, reset included.
`define PCRA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is released.
`define PCRA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

// ===== hw/rtl/pcra_pkg.sv =====
package pcra_pkg;

  localparam int CHANNELS  = 1024;
  localparam int CH_W      = 10;
  // Only channels that the 10-bit index can reach get storage.
  localparam int MEM_DEPTH = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam int EN_W    = 16;
  localparam int COMP_W  = 16;
  localparam int PID_W   = COMP_W + 1;
  localparam int FRAC_W  = 16;
  localparam int RATIO_W = 32;
  localparam int SUM_W   = 48;
  localparam int CNT_W   = 32;
  localparam int STEP_W  = $clog2(SUM_W + 1);

  localparam int QDEPTH = 2;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

  typedef enum logic {
    OP_ACC  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // One classified word as it travels from the front end to the back end.
  typedef struct packed {
    op_t              op;
    logic             ch_ok;
    logic             pid_pos;
    logic [CH_W-1:0]  ch;
    logic [EN_W-1:0]  energy;
    logic [PID_W-1:0] pid;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  typedef enum logic [2:0] {
    BE_CLEAR = 3'd0,
    BE_IDLE  = 3'd1,
    BE_RD    = 3'd2,
    BE_CHK   = 3'd3,
    BE_DIV   = 3'd4,
    BE_RES   = 3'd5
  } be_state_t;

endpackage

// ===== hw/rtl/per_channel_ratio_averager_core.sv =====
// An added hit or a read of a non-empty channel goes through the 48-step radix-2
// divider; other words skip it. The back end works on one word at a time.
// A two-word queue lets the input side accept while the back end divides.
// Reset: synchronous, active low; afterwards a clearing pass writes zero to all
// 1024 channel entries, with full held high until it ends.
module per_channel_ratio_averager_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic                               in_opcode,
  input  logic [pcra_pkg::CH_W-1:0]          in_channel,
  input  logic [pcra_pkg::EN_W-1:0]          in_energy,
  input  logic signed [pcra_pkg::COMP_W-1:0] in_fast_component,
  input  logic signed [pcra_pkg::COMP_W-1:0] in_slow_component,
  output logic                               empty,
  input  logic                               pop,
  output logic [pcra_pkg::CH_W-1:0]          out_channel,
  output logic                               out_accepted,
  output logic [pcra_pkg::RATIO_W-1:0]       out_average_ratio,
  output logic [pcra_pkg::CNT_W-1:0]         out_hit_count,
  output logic                               out_empty_res
);
  import pcra_pkg::*;

  logic   clearing;
  qstat_t q_stat;
  logic   q_push;
  item_t  q_wr_item;
  logic   q_pop;
  item_t  q_rd_item;

  pcra_fe u_fe (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_opcode         (in_opcode),
    .in_channel        (in_channel),
    .in_energy         (in_energy),
    .in_fast_component (in_fast_component),
    .in_slow_component (in_slow_component),
    .clearing          (clearing),
    .q_stat            (q_stat),
    .q_push            (q_push),
    .q_item            (q_wr_item)
  );

  pcra_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_item (q_wr_item),
    .rd_en   (q_pop),
    .rd_item (q_rd_item),
    .stat    (q_stat)
  );

  pcra_be u_be (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .q_item            (q_rd_item),
    .q_pop             (q_pop),
    .clearing          (clearing),
    .pop               (pop),
    .empty             (empty),
    .out_channel       (out_channel),
    .out_accepted      (out_accepted),
    .out_average_ratio (out_average_ratio),
    .out_hit_count     (out_hit_count),
    .out_empty_res     (out_empty_res)
  );

endmodule

// ===== hw/rtl/pcra_fifo.sv =====
module pcra_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  pcra_pkg::item_t wr_item,
  input  logic           rd_en,
  output pcra_pkg::item_t rd_item,
  output pcra_pkg::qstat_t stat
);
  import pcra_pkg::*;

  item_t          slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
    return (p == QAW'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = wr_en ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item    = slot_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == QCW'(QDEPTH));

endmodule

// ===== hw/rtl/pcra_fe.sv =====
module pcra_fe (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic                           in_opcode,
  input  logic [pcra_pkg::CH_W-1:0]      in_channel,
  input  logic [pcra_pkg::EN_W-1:0]      in_energy,
  input  logic signed [pcra_pkg::COMP_W-1:0] in_fast_component,
  input  logic signed [pcra_pkg::COMP_W-1:0] in_slow_component,
  input  logic                           clearing,
  input  pcra_pkg::qstat_t               q_stat,
  output logic                           q_push,
  output pcra_pkg::item_t                q_item
);
  import pcra_pkg::*;

  logic             stage_v_r, stage_v_nxt;
  item_t            stage_r;
  item_t            cls;
  logic [PID_W-1:0] pid;
  logic             accept;

  // Two's complement sum of the components, one bit wider so it cannot wrap.
  assign pid = {in_fast_component[COMP_W-1], in_fast_component}
             + {in_slow_component[COMP_W-1], in_slow_component};

  always_comb begin
    cls.op      = op_t'(in_opcode);
    cls.ch_ok   = ({{(32 - CH_W){1'b0}}, in_channel} < 32'(CHANNELS));
    cls.pid_pos = !pid[PID_W-1] && (pid != '0);
    cls.ch      = in_channel;
    cls.energy  = in_energy;
    cls.pid     = pid;
  end

  assign full   = clearing || (stage_v_r && q_stat.full);
  assign accept = push && !full;
  assign q_push = stage_v_r && !q_stat.full;
  assign q_item = stage_r;

  always_comb begin
    stage_v_nxt = stage_v_r;
    if (accept) begin
      stage_v_nxt = 1'b1;
    end else if (q_push) begin
      stage_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r <= cls;
    end
  end

endmodule

// ===== hw/rtl/pcra_div.sv =====
module pcra_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pcra_pkg::SUM_W-1:0]   dividend,
  input  logic [pcra_pkg::CNT_W-1:0]   divisor,
  output logic                         done,
  output logic [pcra_pkg::SUM_W-1:0]   quo
);
  import pcra_pkg::*;

  logic [SUM_W-1:0]  q_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  // Restoring division, one quotient bit per cycle, MSB first. The dividend
  // shifts out of q_r while quotient bits shift in at the bottom.
  assign trial = {rem_r, q_r[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = !diff[CNT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[SUM_W-2:0], ge};
      rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== hw/rtl/pcra_be.sv =====
module pcra_be (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pcra_pkg::qstat_t              q_stat,
  input  pcra_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          clearing,
  input  logic                          pop,
  output logic                          empty,
  output logic [pcra_pkg::CH_W-1:0]     out_channel,
  output logic                          out_accepted,
  output logic [pcra_pkg::RATIO_W-1:0]  out_average_ratio,
  output logic [pcra_pkg::CNT_W-1:0]    out_hit_count,
  output logic                          out_empty_res
);
  import pcra_pkg::*;

  be_state_t         state_r, state_nxt;
  logic [MEM_AW-1:0] clr_r, clr_nxt;
  item_t             item_r;
  logic [SUM_W-1:0]  rd_sum_r;
  logic [CNT_W-1:0]  rd_cnt_r;

  logic [SUM_W-1:0]  sum_mem [MEM_DEPTH];
  logic [CNT_W-1:0]  cnt_mem [MEM_DEPTH];

  logic              mem_we;
  logic [MEM_AW-1:0] mem_wa;
  logic [SUM_W-1:0]  mem_wsum;
  logic [CNT_W-1:0]  mem_wcnt;
  logic [MEM_AW-1:0] addr;

  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  div_dvd;
  logic [CNT_W-1:0]  div_dvs;
  logic [SUM_W-1:0]  quo;

  logic              need_div;
  logic              res_acc;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_sat;
  logic [CNT_W-1:0]  cnt_inc;
  logic [RATIO_W-1:0] res_avg;
  logic [CNT_W-1:0]  res_cnt;
  logic              slot_free;
  logic              out_load;
  logic              out_v_r;

  assign addr = item_r.ch[MEM_AW-1:0];

  // Division is needed for a hit that gets added, or a read of a channel
  // that holds at least one hit.
  always_comb begin
    if (!item_r.ch_ok) begin
      need_div = 1'b0;
    end else if (item_r.op == OP_ACC) begin
      need_div = item_r.pid_pos;
    end else begin
      need_div = (rd_cnt_r != '0);
    end
  end

  assign res_acc = (item_r.op == OP_ACC) && item_r.ch_ok && item_r.pid_pos;
  assign sum_add = {1'b0, rd_sum_r} + {{(SUM_W + 1 - RATIO_W){1'b0}}, quo[RATIO_W-1:0]};
  assign sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
  assign cnt_inc = (rd_cnt_r == CNT_MAX) ? rd_cnt_r : rd_cnt_r + 1'b1;

  always_comb begin
    res_avg = '0;
    if ((item_r.op == OP_READ) && need_div) begin
      res_avg = (quo[SUM_W-1:RATIO_W] != '0) ? RATIO_MAX : quo[RATIO_W-1:0];
    end
    if (!item_r.ch_ok) begin
      res_cnt = '0;
    end else if (res_acc) begin
      res_cnt = cnt_inc;
    end else begin
      res_cnt = rd_cnt_r;
    end
  end

  assign div_dvd = (item_r.op == OP_ACC)
                 ? {{(SUM_W - EN_W - FRAC_W){1'b0}}, item_r.energy, {FRAC_W{1'b0}}}
                 : rd_sum_r;
  assign div_dvs = (item_r.op == OP_ACC)
                 ? {{(CNT_W - PID_W){1'b0}}, item_r.pid}
                 : rd_cnt_r;

  pcra_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quo      (quo)
  );

  assign slot_free = !out_v_r || pop;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BE_CLEAR: begin
        if (clr_r == MEM_AW'(MEM_DEPTH - 1)) begin
          state_nxt = BE_IDLE;
        end
      end
      BE_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = q_item.ch_ok ? BE_RD : BE_RES;
        end
      end
      BE_RD:   state_nxt = BE_CHK;
      BE_CHK:  state_nxt = need_div ? BE_DIV : BE_RES;
      BE_DIV: begin
        if (div_done) begin
          state_nxt = BE_RES;
        end
      end
      BE_RES: begin
        if (slot_free) begin
          state_nxt = BE_IDLE;
        end
      end
      default: state_nxt = BE_CLEAR;
    endcase
  end

  // State outputs.
  always_comb begin
    q_pop     = 1'b0;
    clearing  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = addr;
    mem_wsum  = sum_sat;
    mem_wcnt  = cnt_inc;
    case (state_r)
      BE_CLEAR: begin
        clearing = 1'b1;
        mem_we   = 1'b1;
        mem_wa   = clr_r;
        mem_wsum = '0;
        mem_wcnt = '0;
      end
      BE_IDLE:  q_pop = !q_stat.empty;
      BE_CHK:   div_start = need_div;
      BE_RES: begin
        out_load = slot_free;
        mem_we   = slot_free && res_acc;
      end
      default: begin
      end
    endcase
  end

  assign clr_nxt = (state_r == BE_CLEAR) ? clr_r + 1'b1 : clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BE_CLEAR;
      clr_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    if (state_r == BE_RD) begin
      rd_sum_r <= sum_mem[addr];
      rd_cnt_r <= cnt_mem[addr];
    end
    if (mem_we) begin
      sum_mem[mem_wa] <= mem_wsum;
      cnt_mem[mem_wa] <= mem_wcnt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_channel       <= item_r.ch;
      out_accepted      <= res_acc;
      out_average_ratio <= res_avg;
      out_hit_count     <= res_cnt;
      out_empty_res     <= (res_cnt == '0);
    end
  end

  assign empty = !out_v_r;

endmodule

// ===== hw/rtl/pcra_chk.sv =====
`include "per_channel_ratio_averager_core_macros.svh"

module pcra_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               full,
  input logic                               empty,
  input logic                               pop,
  input logic [pcra_pkg::CH_W-1:0]          out_channel,
  input logic                               out_accepted,
  input logic [pcra_pkg::RATIO_W-1:0]       out_average_ratio,
  input logic [pcra_pkg::CNT_W-1:0]         out_hit_count,
  input logic                               out_empty_res
);

  // Reset starts the clearing pass with nothing to deliver.
  `PCRA_ASSERT_ALWAYS(a_reset_state, clk, !rst_n |=> full && empty, "reset state wrong")

  // A waiting word holds until it is taken.
  `PCRA_ASSERT(a_out_hold, clk, rst_n, !empty && !pop |=> !empty && $stable(out_hit_count) && $stable(out_average_ratio) && $stable(out_channel), "result changed while waiting")

  // An added hit always leaves a non-zero count.
  `PCRA_ASSERT(a_acc_count, clk, rst_n, !empty && out_accepted |-> !out_empty_res && out_hit_count != 0, "added hit with empty count")

  // An empty channel reports neither a count nor an average.
  `PCRA_ASSERT(a_empty_zero, clk, rst_n, !empty && out_empty_res |-> out_hit_count == 0 && out_average_ratio == 0, "empty channel with data")

endmodule

bind per_channel_ratio_averager_core pcra_chk u_pcra_chk (.*);
